@@ rtl/tensor_lagrange_basis_eval_assert.svh @@
// Assertion macros for the tensor Lagrange basis evaluator checkers.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef TENSOR_LAGRANGE_BASIS_EVAL_ASSERT_SVH
`define TENSOR_LAGRANGE_BASIS_EVAL_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define TLBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define TLBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TLBE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/tlbe_pkg.sv @@
// Shared types, register codes and Q8.24 arithmetic helpers for the
// tensor Lagrange basis evaluator. No dependencies.
package tlbe_pkg;

  localparam int unsigned NODE_SLOTS    = 7;
  localparam int unsigned NUM_NODES_DEF = 5;
  localparam int unsigned COORD_W       = 26;
  localparam int unsigned ORD_W         = 3;
  localparam int unsigned Q_W           = 32;
  localparam int unsigned QBITS         = 32;
  localparam int unsigned DIV_BITS      = 4;
  localparam int unsigned DIV_STG       = QBITS / DIV_BITS;
  localparam int unsigned IN_W          = 88;
  localparam int unsigned OUT_W         = 128;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ORD_W-1:0]          ord_t;
  typedef logic signed [Q_W-1:0]     q_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMENSION  = 3'd0,
    REG_NODE_LOC_0 = 3'd1,
    REG_NODE_LOC_1 = 3'd2,
    REG_NODE_LOC_2 = 3'd3,
    REG_NODE_LOC_3 = 3'd4,
    REG_NODE_LOC_4 = 3'd5,
    REG_NODE_LOC_5 = 3'd6,
    REG_NODE_LOC_6 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    q_t   w;
    q_t   dw;
    logic zero;
  } axis_res_t;

  localparam q_t Q_ONE = 32'sh0100_0000;
  localparam logic [1:0] DIM_RST = 2'd3;
  localparam coord_t [NODE_SLOTS-1:0] NODE_RST = {
    26'sd0, 26'sd0, 26'sd16777216, 26'sd10983266,
    26'sd0, -26'sd10983266, -26'sd16777216
  };
  localparam logic [31:0] OVF_MAG = 32'd65536;

  function automatic q_t sat_mag(input logic neg, input logic [39:0] m);
    q_t r;
    if (neg) begin
      if (m > 40'h00_8000_0000) r = 32'sh8000_0000;
      else r = ~m[31:0] + 32'd1;
    end else begin
      if (m > 40'h00_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [39:0] r;
    ma = a[31] ? (~a + 32'd1) : a;
    mb = b[31] ? (~b + 32'd1) : b;
    p  = {32'b0, ma} * {32'b0, mb};
    r  = 40'((p + 64'd8388608) >> 24);
    return sat_mag(a[31] ^ b[31], r);
  endfunction

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic [32:0] s;
    q_t r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = s[31:0];
    return r;
  endfunction

  function automatic q_t qdiff(input coord_t a, input coord_t b);
    logic [26:0] d;
    d = {a[25], a} - {b[25], b};
    return {{5{d[26]}}, d};
  endfunction

  function automatic coord_t node_pick(input coord_t [NODE_SLOTS-1:0] n, input ord_t k);
    coord_t r;
    r = '0;
    for (int i = 0; i < NODE_SLOTS; i++) begin
      if (k == ord_t'(i)) r = n[i];
    end
    return r;
  endfunction

endpackage

@@ rtl/tlbe_axis.sv @@
// One-axis Lagrange weight and derivative pipeline: product chains,
// pipelined reciprocal and final scaling. Depends on tlbe_pkg.
module tlbe_axis #(
  parameter int unsigned NUM_NODES = tlbe_pkg::NUM_NODES_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  tlbe_pkg::coord_t                             x_i,
  input  tlbe_pkg::ord_t                               k_i,
  input  tlbe_pkg::coord_t [tlbe_pkg::NODE_SLOTS-1:0]  node_i,
  output logic                                         valid_o,
  output tlbe_pkg::axis_res_t                          res_o
);
  import tlbe_pkg::*;

  localparam int unsigned L  = NUM_NODES - 1;
  localparam int unsigned NV = L + DIV_STG + 3;
  localparam ord_t KMax = ord_t'(NUM_NODES - 1);

  logic [NV-1:0] v_q;

  coord_t a_x_q    [L+1];
  ord_t   a_k_q    [L+1];
  logic   a_kbad_q [L+1];
  coord_t a_nk_q   [L+1];
  q_t     a_den_q  [L+1];
  q_t     a_num_q  [L+1];
  q_t     a_inner_q[L+1][L];

  logic [31:0] b_m_q    [DIV_STG+1];
  logic [31:0] b_r_q    [DIV_STG+1];
  logic [31:0] b_q_q    [DIV_STG+1];
  logic        b_neg_q  [DIV_STG+1];
  logic        b_ovf_q  [DIV_STG+1];
  logic        b_zero_q [DIV_STG+1];
  logic        b_kbad_q [DIV_STG+1];
  q_t          b_num_q  [DIV_STG+1];
  q_t          b_sum_q  [DIV_STG+1];
  q_t          b_inner_q[DIV_STG+1][L];

  axis_res_t res_q;
  axis_res_t res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NV-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q[0]    <= x_i;
      a_k_q[0]    <= k_i;
      a_kbad_q[0] <= k_i > KMax;
      a_nk_q[0]   <= node_pick(node_i, k_i);
      a_den_q[0]  <= Q_ONE;
      a_num_q[0]  <= Q_ONE;
      for (int p = 0; p < L; p++) a_inner_q[0][p] <= Q_ONE;
    end
  end

  for (genvar m = 0; m < L; m++) begin : g_a
    coord_t term_n;
    q_t     xd;
    assign term_n = (a_k_q[m] > ord_t'(m)) ? node_i[m] : node_i[m+1];
    assign xd     = qdiff(a_x_q[m], term_n);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_x_q[m+1]    <= a_x_q[m];
        a_k_q[m+1]    <= a_k_q[m];
        a_kbad_q[m+1] <= a_kbad_q[m];
        a_nk_q[m+1]   <= a_nk_q[m];
        a_den_q[m+1]  <= qmul(a_den_q[m], qdiff(a_nk_q[m], term_n));
        a_num_q[m+1]  <= qmul(a_num_q[m], xd);
      end
    end

    for (genvar p = 0; p < L; p++) begin : g_in
      if (p == m) begin : g_hold
        always_ff @(posedge clk_i) begin
          if (en_i) a_inner_q[m+1][p] <= a_inner_q[m][p];
        end
      end else begin : g_mul
        always_ff @(posedge clk_i) begin
          if (en_i) a_inner_q[m+1][p] <= qmul(a_inner_q[m][p], xd);
        end
      end
    end
  end

  logic [31:0] den_mag;
  assign den_mag = a_den_q[L][31] ? (~a_den_q[L] + 32'd1) : a_den_q[L];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_m_q[0]     <= den_mag;
      b_r_q[0]     <= OVF_MAG;
      b_q_q[0]     <= '0;
      b_neg_q[0]   <= a_den_q[L][31];
      b_ovf_q[0]   <= den_mag <= OVF_MAG;
      b_zero_q[0]  <= a_den_q[L] == '0;
      b_kbad_q[0]  <= a_kbad_q[L];
      b_num_q[0]   <= a_num_q[L];
      b_sum_q[0]   <= '0;
      b_inner_q[0] <= a_inner_q[L];
    end
  end

  for (genvar s = 0; s < DIV_STG; s++) begin : g_b
    logic [31:0] half;
    logic [31:0] r_d;
    logic [31:0] q_d;
    assign half = b_m_q[s] >> 1;

    always_comb begin
      logic [DIV_BITS-1:0] chunk;
      logic [32:0]         t;
      chunk = half[QBITS-1-s*DIV_BITS -: DIV_BITS];
      r_d   = b_r_q[s];
      q_d   = b_q_q[s];
      for (int i = 0; i < DIV_BITS; i++) begin
        t     = {r_d, chunk[DIV_BITS-1]};
        chunk = chunk << 1;
        if (t >= {1'b0, b_m_q[s]}) begin
          r_d = 32'(t - {1'b0, b_m_q[s]});
          q_d = {q_d[30:0], 1'b1};
        end else begin
          r_d = t[31:0];
          q_d = {q_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        b_m_q[s+1]     <= b_m_q[s];
        b_r_q[s+1]     <= r_d;
        b_q_q[s+1]     <= q_d;
        b_neg_q[s+1]   <= b_neg_q[s];
        b_ovf_q[s+1]   <= b_ovf_q[s];
        b_zero_q[s+1]  <= b_zero_q[s];
        b_kbad_q[s+1]  <= b_kbad_q[s];
        b_num_q[s+1]   <= b_num_q[s];
        b_inner_q[s+1] <= b_inner_q[s];
      end
    end

    if (s < L) begin : g_sum
      always_ff @(posedge clk_i) begin
        if (en_i) b_sum_q[s+1] <= sat_add(b_sum_q[s], b_inner_q[s][s]);
      end
    end else begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) b_sum_q[s+1] <= b_sum_q[s];
      end
    end
  end

  always_comb begin
    q_t recip;
    recip = sat_mag(b_neg_q[DIV_STG],
                    b_ovf_q[DIV_STG] ? 40'hFF_FFFF_FFFF : {8'b0, b_q_q[DIV_STG]});
    res_d.w    = b_kbad_q[DIV_STG] ? '0 : qmul(b_num_q[DIV_STG], recip);
    res_d.dw   = b_kbad_q[DIV_STG] ? '0 : qmul(b_sum_q[DIV_STG], recip);
    res_d.zero = b_zero_q[DIV_STG] & ~b_kbad_q[DIV_STG];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign valid_o = v_q[NV-1];
  assign res_o   = res_q;

endmodule

@@ rtl/tensor_lagrange_basis_eval.sv @@
// Top level of the tensor-product Lagrange basis evaluator: config
// registers, three axis pipelines, tensor products and output skid.
// Depends on tlbe_pkg and tlbe_axis.
//
//  channel  | dir | handshake                  | payload (low bit up)
//  s_axis   | in  | s_axis_tvalid/tready       | coord_x,y,z, ord_x,y,z
//  m_axis   | out | m_axis_tvalid/tready       | interp_weight, deriv_x,y,z; tuser: degenerate_nodes
//  cfg      | in  | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One request per cycle while the skid stage is empty; results pass the
// per-axis multiply chain (one multiply per stage) and the 4-bit-per-stage
// reciprocal. Reset clears valid bits and loads the register defaults.
// A full skid stage freezes the whole pipeline and drops s_axis_tready.
module tensor_lagrange_basis_eval #(
  parameter int unsigned NUM_NODES = tlbe_pkg::NUM_NODES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // coord_x, coord_y, coord_z, ord_x, ord_y, ord_z, one zero pad bit
  input  logic [tlbe_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // interp_weight, deriv_x, deriv_y, deriv_z
  output logic [tlbe_pkg::OUT_W-1:0]        m_axis_tdata,
  // degenerate_nodes
  output logic [0:0]                        m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [tlbe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tlbe_pkg::COORD_W-1:0]      cfg_wdata_i
);
  import tlbe_pkg::*;

  logic [1:0]                 dim_q;
  coord_t [NODE_SLOTS-1:0]    node_q;
  logic                       dup_q;
  logic                       dup_d;
  logic [1:0]                 dims;
  logic                       en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DIM_RST;
      node_q <= NODE_RST;
      dup_q  <= 1'b0;
    end else begin
      dup_q <= dup_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DIMENSION) dim_q <= cfg_wdata_i[1:0];
        else node_q[3'(cfg_idx_i - REG_NODE_LOC_0)] <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    dup_d = 1'b0;
    for (int a = 0; a < NUM_NODES; a++) begin
      for (int b = a + 1; b < NUM_NODES; b++) begin
        if (node_q[a] == node_q[b]) dup_d = 1'b1;
      end
    end
  end

  assign dims = (dim_q == 2'd0) ? 2'd1 : dim_q;

  coord_t    coord [3];
  ord_t      ord   [3];
  axis_res_t axr   [3];
  logic      axv   [3];

  assign coord[0] = s_axis_tdata[25:0];
  assign coord[1] = s_axis_tdata[51:26];
  assign coord[2] = s_axis_tdata[77:52];
  assign ord[0]   = s_axis_tdata[80:78];
  assign ord[1]   = s_axis_tdata[83:81];
  assign ord[2]   = s_axis_tdata[86:84];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    tlbe_axis #(.NUM_NODES(NUM_NODES)) u_axis (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s_axis_tvalid),
      .x_i     (coord[a]),
      .k_i     (ord[a]),
      .node_i  (node_q),
      .valid_o (axv[a]),
      .res_o   (axr[a])
    );
  end

  logic t1_v_q, t2_v_q;
  q_t   t1_w_q, t1_d0_q, t1_d1_q, t1_d2_q, t1_w2_q, t1_dw2_q;
  logic t1_degen_q, t2_degen_q;
  q_t   t2_w_q, t2_d0_q, t2_d1_q, t2_d2_q;
  logic [1:0] t1_dims_q, t2_dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
    end else if (en) begin
      t1_v_q <= axv[0] & axv[1] & axv[2];
      t2_v_q <= t1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_dims_q  <= dims;
      t1_degen_q <= dup_q | axr[0].zero | ((dims >= 2'd2) & axr[1].zero)
                  | ((dims == 2'd3) & axr[2].zero);
      t1_w2_q    <= axr[2].w;
      t1_dw2_q   <= axr[2].dw;
      if (dims >= 2'd2) begin
        t1_w_q  <= qmul(axr[0].w, axr[1].w);
        t1_d0_q <= qmul(axr[0].dw, axr[1].w);
        t1_d1_q <= qmul(axr[0].w, axr[1].dw);
        t1_d2_q <= qmul(axr[0].w, axr[1].w);
      end else begin
        t1_w_q  <= axr[0].w;
        t1_d0_q <= axr[0].dw;
        t1_d1_q <= '0;
        t1_d2_q <= '0;
      end

      t2_dims_q  <= t1_dims_q;
      t2_degen_q <= t1_degen_q;
      if (t1_dims_q == 2'd3) begin
        t2_w_q  <= qmul(t1_w_q, t1_w2_q);
        t2_d0_q <= qmul(t1_d0_q, t1_w2_q);
        t2_d1_q <= qmul(t1_d1_q, t1_w2_q);
        t2_d2_q <= qmul(t1_d2_q, t1_dw2_q);
      end else begin
        t2_w_q  <= t1_w_q;
        t2_d0_q <= t1_d0_q;
        t2_d1_q <= t1_d1_q;
        t2_d2_q <= t1_d2_q;
      end
    end
  end

  logic [OUT_W-1:0] fin_data;
  q_t               fin_dy, fin_dz;

  assign fin_dy   = (t2_dims_q >= 2'd2) ? t2_d1_q : '0;
  assign fin_dz   = (t2_dims_q == 2'd3) ? t2_d2_q : '0;
  assign fin_data = t2_degen_q ? '0 : {fin_dz, fin_dy, t2_d0_q, t2_w_q};

  logic             out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic             out_load, out_from_skid, skid_load, take;
  logic [OUT_W-1:0] out_data_q, skid_data_q;
  logic             out_user_q, skid_user_q;

  assign en   = ~skid_v_q;
  assign take = out_v_q & m_axis_tready;

  always_comb begin
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    out_load      = 1'b0;
    out_from_skid = 1'b0;
    skid_load     = 1'b0;
    if (skid_v_q) begin
      if (take) begin
        out_load      = 1'b1;
        out_from_skid = 1'b1;
        skid_v_d      = 1'b0;
      end
    end else if (!out_v_q || take) begin
      out_v_d  = t2_v_q;
      out_load = t2_v_q;
    end else if (t2_v_q) begin
      skid_v_d  = 1'b1;
      skid_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_from_skid ? skid_data_q : fin_data;
      out_user_q <= out_from_skid ? skid_user_q : t2_degen_q;
    end
    if (skid_load) begin
      skid_data_q <= fin_data;
      skid_user_q <= t2_degen_q;
    end
  end

  assign s_axis_tready   = ~skid_v_q;
  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

endmodule

@@ rtl/tlbe_checker.sv @@
// Port-level checker for the tensor Lagrange basis evaluator, bound to
// the top level. Depends on tlbe_pkg and the assertion macro header.
`include "tensor_lagrange_basis_eval_assert.svh"

module tlbe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [tlbe_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic [0:0]                  m_axis_tuser
);
  import tlbe_pkg::*;

  `TLBE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output request changed while stalled")
  `TLBE_ASSERT_IMPL(a_degen_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "degenerate result with nonzero weights")
  `TLBE_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
  `TLBE_ASSERT_IMPL(a_stall_cause, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready), "input stalled without output backpressure")

endmodule

bind tensor_lagrange_basis_eval tlbe_checker u_tlbe_checker (.*);

@@ test/tb.sv @@
// Testbench for tensor_lagrange_basis_eval: drives point/ordinal requests
// under random bursts and output stalls, and checks each result against an
// in-bench Q8.24 Lagrange predictor. Depends on tlbe_pkg and the RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbe_pkg::*;

  localparam int NODES = NUM_NODES_DEF;
  localparam longint QONE = 64'sd16777216;

  typedef struct {
    logic [31:0] weight;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic        degen;
  } basis_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [COORD_W-1:0] cfg_wdata_i = '0;

  tensor_lagrange_basis_eval u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [1:0] dim_reg;
  longint node_pos [NODE_SLOTS];
  basis_res_t pending_q [$];
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_degen = 0;
  int burst_left = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_signed(bit neg, longint unsigned m);
    if (neg) begin
      if (m > 64'd2147483648) m = 64'd2147483648;
      return -longint'(m);
    end
    if (m > 64'd2147483647) m = 64'd2147483647;
    return longint'(m);
  endfunction

  function automatic longint unsigned magn(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = magn(a) * magn(b);
    return sat_signed((a < 0) != (b < 0), (p + 64'd8388608) >> 24);
  endfunction

  function automatic longint fx_recip(longint d);
    longint unsigned m;
    m = magn(d);
    return sat_signed(d < 0, ((64'd1 << 48) + (m >> 1)) / m);
  endfunction

  function automatic bit lagrange_1d(longint x, int k, output longint w, output longint dw);
    longint den, num, sum, r, inner;
    den = QONE;
    num = QONE;
    sum = 0;
    w = 0;
    dw = 0;
    if (k >= NODES) return 1'b1;
    for (int j = 0; j < NODES; j++)
      if (j != k) den = fx_mul(den, sat32(node_pos[k] - node_pos[j]));
    if (den == 0) return 1'b0;
    r = fx_recip(den);
    for (int j = 0; j < NODES; j++) begin
      if (j == k) continue;
      num = fx_mul(num, sat32(x - node_pos[j]));
      inner = QONE;
      for (int i = 0; i < NODES; i++)
        if (i != j && i != k) inner = fx_mul(inner, sat32(x - node_pos[i]));
      sum = sat32(sum + inner);
    end
    w = fx_mul(num, r);
    dw = fx_mul(sum, r);
    return 1'b1;
  endfunction

  function automatic basis_res_t predict_basis(coord_t c [3], ord_t o [3]);
    int dims;
    longint w [3], dw [3], res [4];
    bit degen;
    basis_res_t e;
    dims = (dim_reg == 0) ? 1 : dim_reg;
    degen = 1'b0;
    res = '{0, 0, 0, 0};
    w = '{0, 0, 0};
    dw = '{0, 0, 0};
    for (int a = 0; a < NODES; a++)
      for (int b = a + 1; b < NODES; b++)
        if (node_pos[a] == node_pos[b]) degen = 1'b1;
    for (int a = 0; a < dims; a++)
      if (!lagrange_1d(longint'(c[a]), int'(o[a]), w[a], dw[a])) degen = 1'b1;
    if (!degen) begin
      res[0] = QONE;
      for (int a = 0; a < dims; a++) res[0] = fx_mul(res[0], w[a]);
      for (int d = 0; d < dims; d++) begin
        res[1+d] = QONE;
        for (int a = 0; a < dims; a++)
          res[1+d] = fx_mul(res[1+d], a == d ? dw[a] : w[a]);
      end
    end
    e.weight = res[0][31:0];
    e.dx = res[1][31:0];
    e.dy = res[2][31:0];
    e.dz = res[3][31:0];
    e.degen = degen;
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("result %0d: %s got %h want %h", n_res, what, got, want);
  endtask

  task automatic send_request(coord_t c [3], ord_t o [3]);
    bit rdy;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, o[2], o[1], o[0], c[2], c[1], c[0]};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    pending_q.push_back(predict_basis(c, o));
    n_req++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [COORD_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DIMENSION) dim_reg = val[1:0];
    else node_pos[int'(idx) - 1] = longint'(coord_t'(val));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord(bit wild);
    if (wild) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 33554432)) - 16777216);
  endfunction

  task automatic send_random(int count);
    coord_t c [3];
    ord_t o [3];
    bit noisy;
    repeat (count) begin
      noisy = ($urandom_range(0, 9) == 0);
      for (int a = 0; a < 3; a++) begin
        c[a] = ($urandom_range(0, 7) == 0) ? coord_t'(node_pos[$urandom_range(0, NODES-1)])
                                             : rand_coord(noisy);
        o[a] = noisy ? ord_t'($urandom) : ord_t'($urandom_range(0, NODES-1));
      end
      send_request(c, o);
    end
  endtask

  task automatic load_nodes(longint p [NODE_SLOTS]);
    for (int i = 0; i < NODE_SLOTS; i++)
      write_reg(cfg_reg_e'(i + 1), p[i][COORD_W-1:0]);
  endtask

  task automatic test_directed;
    coord_t ext [6];
    coord_t c [3];
    ord_t o [3];
    ext = '{coord_t'(-16777216), coord_t'(16777216), coord_t'(0),
            coord_t'(26'h1FFFFFF), coord_t'(26'h2000000), coord_t'(10983266)};
    for (int i = 0; i < 8; i++) begin
      c = '{ext[i % 6], ext[(i + 2) % 6], ext[(i + 4) % 6]};
      o = '{ord_t'(i), ord_t'(7 - i), ord_t'(i % NODES)};
      send_request(c, o);
    end
    for (int i = 0; i < 6; i++) begin
      c = '{ext[i], ext[5 - i], ext[i]};
      o = '{ord_t'(i % NODES), ord_t'((i + 1) % NODES), ord_t'((i + 3) % NODES)};
      send_request(c, o);
    end
    drain();
  endtask

  task automatic test_dimensions;
    for (int d = 0; d < 4; d++) begin
      write_reg(REG_DIMENSION, {24'($urandom), d[1:0]});
      send_random(120);
      drain();
    end
  endtask

  task automatic test_node_sets;
    longint p [NODE_SLOTS];
    for (int s = 0; s < 6; s++) begin
      for (int i = 0; i < NODE_SLOTS; i++)
        p[i] = longint'(rand_coord(1'b0));
      case (s)
        0: p[0:4] = '{-16777216, -8388608, 0, 8388608, 16777216};
        1: p[0:4] = '{16777216, -16777216, 4, -4, 0};
        2: p[3] = p[1];
        3: p[0:4] = '{0, 1, 2, 3, 4};
        default: ;
      endcase
      load_nodes(p);
      write_reg(REG_DIMENSION, 26'($urandom_range(1, 3)));
      send_random(150);
      drain();
    end
  endtask

  task automatic test_defaults;
    longint p [NODE_SLOTS];
    p = '{-16777216, -10983266, 0, 10983266, 16777216, 0, 0};
    load_nodes(p);
    write_reg(REG_DIMENSION, 26'd3);
    send_random(156);
    drain();
  endtask

  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= $urandom_range(10, 80);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= stall_cnt[2];
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(negedge clk_i) begin
    basis_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_res++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("result %0d: no request outstanding", n_res);
      end else begin
        e = pending_q.pop_front();
        if (e.degen) n_degen++;
        if (m_axis_tdata[31:0] !== e.weight)
          report_mismatch("interp_weight", m_axis_tdata[31:0], e.weight);
        if (m_axis_tdata[63:32] !== e.dx)
          report_mismatch("deriv_x", m_axis_tdata[63:32], e.dx);
        if (m_axis_tdata[95:64] !== e.dy)
          report_mismatch("deriv_y", m_axis_tdata[95:64], e.dy);
        if (m_axis_tdata[127:96] !== e.dz)
          report_mismatch("deriv_z", m_axis_tdata[127:96], e.dz);
        if (m_axis_tuser[0] !== e.degen)
          report_mismatch("degenerate_nodes", 32'(m_axis_tuser), 32'(e.degen));
      end
    end
  end

  initial begin
    dim_reg = DIM_RST;
    for (int i = 0; i < NODE_SLOTS; i++) node_pos[i] = longint'(NODE_RST[i]);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_dimensions();
    test_node_sets();
    test_defaults();
    $display("%0d requests sent, %0d results checked, %0d degenerate", n_req, n_res, n_degen);
    $display("covered dimensions 0-3, default, extreme and coincident node sets");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tensor_lagrange_basis_eval: match");
    end else begin
      $display("tensor_lagrange_basis_eval: mismatch");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tensor_lagrange_basis_eval: mismatch");
    $finish;
  end
endmodule
